// ----- src/coin_changer_with_inventory_unit_macros.svh -----
// Assertion macros shared by the coin changer RTL.
`ifndef COIN_CHANGER_WITH_INVENTORY_UNIT_MACROS_SVH
`define COIN_CHANGER_WITH_INVENTORY_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define CCI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CCI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/cci_pkg.sv -----
// Package with the constants, codes, denomination table and shared types of the coin changer.
package cci_pkg;

  localparam int NUM_DENOMS  = 10;
  localparam int COUNT_WIDTH = 8;

  localparam int SLOT_W   = 4;
  localparam int IDX_W    = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam int QTY_W    = 8;
  localparam int K_W      = $clog2(QTY_W);
  localparam int CREDIT_W = 20;
  localparam int PRICE_W  = 20;
  localparam int DENOM_W  = 14;
  localparam int ACC_W    = 22;
  localparam int CAP_W    = (COUNT_WIDTH > QTY_W) ? COUNT_WIDTH : QTY_W;

  localparam logic [QTY_W-1:0]       QTY_MAX     = {QTY_W{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(10);
  localparam logic [CREDIT_W:0]      CREDIT_MAX  = (CREDIT_W+1)'(1000000);
  localparam logic [CREDIT_W-1:0]    MIN_CHANGE  = CREDIT_W'(10);

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_BUY     = 2'd1,
    OP_CHANGE  = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DENOM = 3'd1,
    ST_NO_FUNDS  = 3'd2,
    ST_NO_CHANGE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic             hit;
    logic [QTY_W-1:0] q;
    logic [ACC_W-1:0] acc;
  } trial_t;

  // Value in grosze of each denomination slot; slots without a coin read as zero.
  function automatic logic [DENOM_W-1:0] denom_value(input logic [SLOT_W-1:0] slot);
    logic [DENOM_W-1:0] v;
    unique case (slot)
      4'd0:    v = DENOM_W'(10);
      4'd1:    v = DENOM_W'(20);
      4'd2:    v = DENOM_W'(50);
      4'd3:    v = DENOM_W'(100);
      4'd4:    v = DENOM_W'(200);
      4'd5:    v = DENOM_W'(500);
      4'd6:    v = DENOM_W'(1000);
      4'd7:    v = DENOM_W'(2000);
      4'd8:    v = DENOM_W'(5000);
      4'd9:    v = DENOM_W'(10000);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/cci_trial.sv -----
// Shared add and compare unit that tries one quantity bit of the greedy payout.
module cci_trial (
  input  logic [cci_pkg::ACC_W-1:0]    acc,
  input  logic [cci_pkg::QTY_W-1:0]    q,
  input  logic [cci_pkg::K_W-1:0]      k,
  input  logic [cci_pkg::DENOM_W-1:0]  d,
  input  logic [cci_pkg::QTY_W-1:0]    cap,
  input  logic [cci_pkg::CREDIT_W-1:0] target,
  output cci_pkg::trial_t              res
);
  import cci_pkg::*;

  logic [QTY_W-1:0] trial_q;
  logic [ACC_W-1:0] step;
  logic [ACC_W-1:0] sum;
  logic             hit;

  // A bit of the quantity is kept when it stays within the cap and the running
  // total of paid grosze does not pass the credit.
  always_comb begin
    trial_q = q | (QTY_W'(1) << k);
    step    = ACC_W'(d) << k;
    sum     = acc + step;
    hit     = (trial_q <= cap) && (sum <= ACC_W'(target));
    res.hit = hit;
    res.q   = hit ? trial_q : q;
    res.acc = hit ? sum : acc;
  end

endmodule

// ----- src/coin_changer_with_inventory_unit.sv -----
// Top level of the coin changer: sequencer, credit, coin inventory and result register.
//
//   Channel   Handshake      Payload
//   command   start / busy   op, coin_index, price
//   result    strobe         status, coin_slot, coin_quantity, balance, last
//
// Deposit, buy and query give their single result word from the execute state.
// Change runs a search in which one shared add and compare unit settles one quantity
// bit per cycle, eight per denomination; then a walk over the slots sends the payout
// as one word per denomination used.
// Reset is synchronous and restores a zero credit and ten pieces of each denomination.
// Result words are never held back; the receiver must take each in its strobe cycle.
module coin_changer_with_inventory_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [cci_pkg::SLOT_W-1:0]    coin_index,
  input  logic [cci_pkg::PRICE_W-1:0]   price,
  output logic                          strobe,
  output logic [2:0]                    status,
  output logic [cci_pkg::SLOT_W-1:0]    coin_slot,
  output logic [cci_pkg::QTY_W-1:0]     coin_quantity,
  output logic [cci_pkg::CREDIT_W-1:0]  balance,
  output logic                          last
);
  import cci_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_CHECK  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t                 state;
  op_t                    op_r;
  logic [SLOT_W-1:0]      idx_r;
  logic [PRICE_W-1:0]     price_r;
  logic [CREDIT_W-1:0]    credit;
  logic [CREDIT_W-1:0]    target;
  logic [COUNT_WIDTH-1:0] counts [NUM_DENOMS];
  logic [QTY_W-1:0]       take [NUM_DENOMS];
  logic [IDX_W-1:0]       walk_idx;
  logic [IDX_W-1:0]       low_idx;
  logic [K_W-1:0]         k;
  logic [QTY_W-1:0]       q;
  logic [ACC_W-1:0]       acc;
  logic                   any_take;

  logic [IDX_W-1:0]       rd_idx;
  logic [COUNT_WIDTH-1:0] count_rd;
  logic [DENOM_W-1:0]     dep_val;
  logic [DENOM_W-1:0]     walk_val;
  logic [CREDIT_W:0]      dep_sum;
  logic                   slot_ok;
  logic                   dep_full;
  logic [QTY_W-1:0]       cap;
  logic [QTY_W-1:0]       take_rd;
  trial_t                 trial;

  assign busy = (state != S_IDLE);

  always_comb begin
    rd_idx   = (state == S_EXEC) ? idx_r[IDX_W-1:0] : walk_idx;
    count_rd = counts[rd_idx];
    take_rd  = take[walk_idx];
    dep_val  = denom_value(idx_r);
    walk_val = denom_value(SLOT_W'(walk_idx));
    slot_ok  = ({1'b0, idx_r} < (SLOT_W+1)'(NUM_DENOMS)) && (dep_val != '0);
    dep_sum  = (CREDIT_W+1)'(credit) + (CREDIT_W+1)'(dep_val);
    dep_full = (dep_sum > CREDIT_MAX) || (count_rd == COUNT_MAX);
    if (walk_val == '0) begin
      cap = '0;
    end else if (CAP_W'(count_rd) > CAP_W'(QTY_MAX)) begin
      cap = QTY_MAX;
    end else begin
      cap = QTY_W'(CAP_W'(count_rd));
    end
  end

  cci_trial u_trial (
    .acc    (acc),
    .q      (q),
    .k      (k),
    .d      (walk_val),
    .cap    (cap),
    .target (target),
    .res    (trial)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      credit <= '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
        counts[i] <= COUNT_RESET;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            op_r    <= op_t'(op);
            idx_r   <= coin_index;
            price_r <= price;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          last          <= 1'b1;
          coin_slot     <= '0;
          coin_quantity <= '0;
          unique case (op_r)
            OP_DEPOSIT: begin
              strobe <= 1'b1;
              state  <= S_IDLE;
              if (!slot_ok) begin
                status  <= ST_BAD_DENOM;
                balance <= credit;
              end else if (dep_full) begin
                status  <= ST_FULL;
                balance <= credit;
              end else begin
                status         <= ST_OK;
                credit         <= dep_sum[CREDIT_W-1:0];
                balance        <= dep_sum[CREDIT_W-1:0];
                counts[rd_idx] <= count_rd + COUNT_WIDTH'(1);
              end
            end
            OP_BUY: begin
              strobe <= 1'b1;
              state  <= S_IDLE;
              if (price_r > credit) begin
                status  <= ST_NO_FUNDS;
                balance <= credit;
              end else begin
                status  <= ST_OK;
                credit  <= credit - price_r;
                balance <= credit - price_r;
              end
            end
            OP_CHANGE: begin
              target <= credit;
              credit <= '0;
              if (credit < MIN_CHANGE) begin
                strobe  <= 1'b1;
                status  <= ST_NO_CHANGE;
                balance <= '0;
                state   <= S_IDLE;
              end else begin
                strobe   <= 1'b0;
                walk_idx <= IDX_W'(NUM_DENOMS - 1);
                k        <= K_W'(QTY_W - 1);
                acc      <= '0;
                q        <= '0;
                any_take <= 1'b0;
                state    <= S_SEARCH;
              end
            end
            OP_QUERY: begin
              strobe  <= 1'b1;
              state   <= S_IDLE;
              status  <= ST_OK;
              balance <= credit;
            end
          endcase
        end
        S_SEARCH: begin
          strobe <= 1'b0;
          acc    <= trial.acc;
          if (k == '0) begin
            take[walk_idx] <= trial.q;
            if (trial.q != '0) begin
              any_take <= 1'b1;
              low_idx  <= walk_idx;
            end
            q <= '0;
            k <= K_W'(QTY_W - 1);
            if (walk_idx == '0) begin
              state <= S_CHECK;
            end else begin
              walk_idx <= walk_idx - IDX_W'(1);
            end
          end else begin
            q <= trial.q;
            k <= k - K_W'(1);
          end
        end
        S_CHECK: begin
          if (!any_take || (acc != ACC_W'(target))) begin
            strobe        <= 1'b1;
            status        <= ST_NO_CHANGE;
            coin_slot     <= '0;
            coin_quantity <= '0;
            balance       <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            strobe   <= 1'b0;
            walk_idx <= IDX_W'(NUM_DENOMS - 1);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe <= (take_rd != '0);
          if (take_rd != '0) begin
            status           <= ST_OK;
            coin_slot        <= SLOT_W'(walk_idx);
            coin_quantity    <= take_rd;
            balance          <= '0;
            last             <= (walk_idx == low_idx);
            counts[walk_idx] <= count_rd - COUNT_WIDTH'(take_rd);
          end
          if (walk_idx == low_idx) begin
            state <= S_IDLE;
          end else begin
            walk_idx <= walk_idx - IDX_W'(1);
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

`include "coin_changer_with_inventory_unit_macros.svh"

  `CCI_ASSERT(a_more_words_keep_busy, strobe && !last |-> busy, "Non-final word without busy.")
  `CCI_ASSERT(a_accept_no_word, start && !busy |=> !strobe && busy, "Word right after accept.")
  `CCI_ASSERT(a_fail_single, strobe && (status != ST_OK) |-> last && (coin_quantity == '0), "Failure word not single.")
  `CCI_ASSERT(a_payout_zero_bal, strobe && (coin_quantity != '0) |-> (balance == '0) && (status == ST_OK), "Payout word with balance.")
  `CCI_ASSERT_ALWAYS(a_reset_quiet, rst |=> !strobe && !busy, "Activity after reset.")

endmodule
